// ===== hw/rtl/uad_pkg.sv =====
// Package: shared types, constants and helpers for the unsigned to ASCII digits block.
`default_nettype none
package uad_pkg;

  localparam int unsigned UAD_MAX_DIGITS = 10;
  localparam int unsigned UAD_VALUE_W    = 32;
  localparam int unsigned UAD_DIGIT_W    = 4;
  localparam int unsigned UAD_CHAR_W     = 7;

  // Reciprocal of ten: floor(v * RECIP / 2**SHIFT) == v / 10 for any 32-bit v.
  localparam logic [UAD_VALUE_W-1:0] UAD_RECIP_10 = 32'hCCCC_CCCD;
  localparam int unsigned            UAD_DIV_SHIFT = 35;
  localparam int unsigned            UAD_PROD_W    = 2 * UAD_VALUE_W;

  localparam logic [UAD_CHAR_W-1:0]  UAD_ASCII_ZERO = 7'h30;
  localparam logic [UAD_CHAR_W-1:0]  UAD_ASCII_A    = 7'h41;
  localparam logic [UAD_DIGIT_W-1:0] UAD_TEN        = 4'd10;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_STEP,
    ST_SUB,
    ST_EMIT
  } uad_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic mul;
    logic dec_step;
    logic hex_step;
    logic emit;
  } uad_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic hex;
    logic step_zero;
    logic emit_last;
    logic out_free;
  } uad_sts_t;

  function automatic logic [UAD_CHAR_W-1:0] uad_to_ascii(input logic [UAD_DIGIT_W-1:0] d);
    logic [UAD_CHAR_W-1:0] c;
    if (d < UAD_TEN) begin
      c = UAD_ASCII_ZERO + UAD_CHAR_W'(d);
    end else begin
      c = UAD_ASCII_A + UAD_CHAR_W'(d - UAD_TEN);
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/uad_if.sv =====
// Interfaces: input and result channels of the unsigned to ASCII digits block.
`default_nettype none
interface uad_in_if
  import uad_pkg::*;
();
  logic                   valid;
  logic                   ready;
  logic [UAD_VALUE_W-1:0] value;
  logic                   req_type;

  modport source (output valid, output value, output req_type, input ready);
  modport sink   (input valid, input value, input req_type, output ready);
endinterface

interface uad_out_if
  import uad_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [UAD_CHAR_W-1:0] ascii_char;
  logic                  last;

  modport source (output valid, output ascii_char, output last, input ready);
  modport sink   (input valid, input ascii_char, input last, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/uad_ctrl.sv =====
// Controller: state machine that sequences load, digit steps and character emits.
`default_nettype none
module uad_ctrl
  import uad_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire uad_sts_t sts,
  output uad_cmd_t      cmd
);

  uad_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_STEP;
        end
      end
      ST_STEP: begin
        if (!sts.hex) begin
          state_nxt = ST_SUB;
        end else if (sts.step_zero) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_SUB: begin
        state_nxt = sts.step_zero ? ST_EMIT : ST_STEP;
      end
      ST_EMIT: begin
        if (sts.out_free && sts.emit_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_STEP: begin
        cmd.hex_step = sts.hex;
        cmd.mul      = !sts.hex;
      end
      ST_SUB: begin
        cmd.dec_step = 1'b1;
      end
      ST_EMIT: begin
        cmd.emit = sts.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== hw/rtl/uad_dp.sv =====
// Datapath: working value, reciprocal divide, digit store and output register.
`default_nettype none
module uad_dp
  import uad_pkg::*;
#(
  parameter int unsigned MAX_DIGITS = UAD_MAX_DIGITS
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic [UAD_VALUE_W-1:0] in_value,
  input  wire logic                   in_req_type,
  input  wire uad_cmd_t               cmd,
  output uad_sts_t                    sts,
  input  wire logic                   out_ready,
  output logic                        out_valid,
  output logic [UAD_CHAR_W-1:0]       out_ascii_char,
  output logic                        out_last
);

  localparam int unsigned CNT_W = $clog2(MAX_DIGITS + 1);
  localparam int unsigned IDX_W = $clog2(MAX_DIGITS);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_DIGITS);
  localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

  logic [UAD_VALUE_W-1:0] wv_r, wv_nxt;
  logic [UAD_VALUE_W-1:0] q_r, q_nxt;
  logic                   hex_r, hex_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [UAD_DIGIT_W-1:0] store_r [MAX_DIGITS];
  logic                   out_valid_r, out_valid_nxt;
  logic [UAD_CHAR_W-1:0]  char_r, char_nxt;
  logic                   last_r, last_nxt;

  logic [UAD_PROD_W-1:0]  prod;
  logic [UAD_VALUE_W-1:0] rem;
  logic [UAD_DIGIT_W-1:0] digit;
  logic                   wr_en;
  logic [CNT_W-1:0]       cnt_m1;
  logic [IDX_W-1:0]       wr_idx;
  logic [IDX_W-1:0]       rd_idx;

  assign prod   = {{UAD_VALUE_W{1'b0}}, wv_r} * {{UAD_VALUE_W{1'b0}}, UAD_RECIP_10};
  assign q_nxt  = cmd.mul ? UAD_VALUE_W'(prod >> UAD_DIV_SHIFT) : q_r;
  // remainder = v - 10*q, with 10*q built from two shifts
  assign rem    = wv_r - ((q_r << 3) + (q_r << 1));
  assign digit  = hex_r ? wv_r[UAD_DIGIT_W-1:0] : rem[UAD_DIGIT_W-1:0];
  assign cnt_m1 = cnt_r - CNT_ONE;
  assign wr_idx = cnt_r[IDX_W-1:0];
  assign rd_idx = cnt_m1[IDX_W-1:0];
  // drop the most significant digits once the store is full
  assign wr_en  = (cmd.dec_step || cmd.hex_step) && (cnt_r < CNT_MAX);

  always_comb begin
    wv_nxt  = wv_r;
    hex_nxt = hex_r;
    cnt_nxt = cnt_r;
    if (cmd.load) begin
      wv_nxt  = in_value;
      hex_nxt = in_req_type;
      cnt_nxt = '0;
    end else if (cmd.dec_step) begin
      wv_nxt = q_r;
    end else if (cmd.hex_step) begin
      wv_nxt = wv_r >> UAD_DIGIT_W;
    end
    if (wr_en) begin
      cnt_nxt = cnt_r + CNT_ONE;
    end else if (cmd.emit) begin
      cnt_nxt = cnt_m1;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    char_nxt      = char_r;
    last_nxt      = last_r;
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
      char_nxt      = uad_to_ascii(store_r[rd_idx]);
      last_nxt      = (cnt_r == CNT_ONE);
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wv_r        <= '0;
      cnt_r       <= '0;
      hex_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      wv_r        <= wv_nxt;
      cnt_r       <= cnt_nxt;
      hex_r       <= hex_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r    <= q_nxt;
    char_r <= char_nxt;
    last_r <= last_nxt;
    if (wr_en) begin
      store_r[wr_idx] <= digit;
    end
  end

  always_comb begin
    sts.hex       = hex_r;
    sts.step_zero = hex_r ? ((wv_r >> UAD_DIGIT_W) == '0) : (q_r == '0);
    sts.emit_last = (cnt_r == CNT_ONE);
    sts.out_free  = !out_valid_r || out_ready;
  end

  assign out_valid      = out_valid_r;
  assign out_ascii_char = char_r;
  assign out_last       = last_r;

endmodule
`default_nettype wire

// ===== hw/rtl/unsigned_to_ascii_digits.sv =====
// Top level: converts a 32-bit unsigned value to ASCII decimal or hex characters.
//
//  channel   | dir | payload               | handshake
//  ----------+-----+-----------------------+-------------------------------
//  in_item   | in  | value[31:0], req_type | valid/ready, taken when idle
//  out_item  | out | ascii_char[6:0], last | valid/ready, registered output
//
// Sequence: take the item, then per decimal digit a reciprocal multiply step
// followed by a remainder and store step, or per hex digit a single shift
// step, then emit the characters while out_item is not stalled. No new item
// is taken until the last character has been emitted.
// Reset: rst_n is synchronous, active low; it idles the controller and drops
// out_item.valid. Stalls on out_item hold the character and pause emission.
`default_nettype none
module unsigned_to_ascii_digits
  import uad_pkg::*;
#(
  parameter int unsigned MAX_DIGITS = UAD_MAX_DIGITS
) (
  input  wire logic clk,
  input  wire logic rst_n,
  uad_in_if.sink    in_item,
  uad_out_if.source out_item
);

  uad_cmd_t cmd;
  uad_sts_t sts;

  // Sequence the item: load, digit steps least significant first, then emit
  // most significant first.
  uad_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_item.valid),
    .in_ready (in_item.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Hold the working value and digits; drive the registered output item.
  uad_dp #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_value       (in_item.value),
    .in_req_type    (in_item.req_type),
    .cmd            (cmd),
    .sts            (sts),
    .out_ready      (out_item.ready),
    .out_valid      (out_item.valid),
    .out_ascii_char (out_item.ascii_char),
    .out_last       (out_item.last)
  );

endmodule
`default_nettype wire

// ===== hw/rtl/uad_chk.sv =====
// Checker: port-level assertions for the unsigned to ASCII digits block, bound to the top.
`default_nettype none
module uad_chk
  import uad_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  in_valid,
  input wire logic                  in_ready,
  input wire logic                  out_valid,
  input wire logic                  out_ready,
  input wire logic [UAD_CHAR_W-1:0] out_ascii_char,
  input wire logic                  out_last
);

  // Only decimal and hex digit characters (0-9, A-F) leave the block.
  a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_ascii_char >= 7'h30) && (out_ascii_char <= 7'h39)) ||
                  ((out_ascii_char >= 7'h41) && (out_ascii_char <= 7'h46)))
    else $error("uad: character outside 0-9 and A-F");

  // One item at a time: taking an item closes the input.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("uad: input still open after taking an item");

  // No new item while characters of the current one remain.
  a_not_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !out_last) |-> !in_ready)
    else $error("uad: input open before last character");

  // A stalled character holds.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_ascii_char) && $stable(out_last)))
    else $error("uad: stalled output changed");

endmodule

bind unsigned_to_ascii_digits uad_chk u_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_item.valid),
  .in_ready       (in_item.ready),
  .out_valid      (out_item.valid),
  .out_ready      (out_item.ready),
  .out_ascii_char (out_item.ascii_char),
  .out_last       (out_item.last)
);
`default_nettype wire
